### hw/rtl/sfs_pkg.sv
package sfs_pkg;

  // Fixed widths of the request and result fields.
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned SLOT_IDX_W = 8;
  localparam int unsigned ENTRY_W    = 64;
  localparam int unsigned OUT_SLOT_W = 6;
  localparam int unsigned COUNT_W    = 6;

  // Request commands. The fourth code is not defined and does nothing.
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  // Control of the free stack for one cycle.
  typedef struct packed {
    logic rd;    // read the entry on top of the stack
    logic pop;   // drop the top entry
    logic push;  // push a slot number
  } stk_ctrl_t;

  // Control of the slot table for one cycle.
  typedef struct packed {
    logic rd;    // read data word and used bit
    logic wr;    // write data word and set the used bit
    logic clr;   // clear the used bit
  } tbl_ctrl_t;

endpackage

### hw/rtl/sfs_free_stack.sv
module sfs_free_stack #(
  parameter int unsigned NUM_SLOTS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sfs_pkg::stk_ctrl_t            ctrl_i,
  input  logic [$clog2(NUM_SLOTS)-1:0]  push_slot_i,
  output logic [$clog2(NUM_SLOTS)-1:0]  top_slot_o,
  output logic [$clog2(NUM_SLOTS+1)-1:0] depth_o
);

  localparam int unsigned PTR_W = $clog2(NUM_SLOTS);
  localparam int unsigned CNT_W = $clog2(NUM_SLOTS + 1);

  logic [PTR_W-1:0]     stack_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] written_q, written_d;
  logic [CNT_W-1:0]     depth_q, depth_d;
  logic [PTR_W-1:0]     top_addr, push_addr;
  logic                 can_push;
  logic [PTR_W-1:0]     rd_mem_q, rd_addr_q;
  logic                 rd_written_q;

  assign top_addr  = PTR_W'(depth_q - CNT_W'(1));
  assign push_addr = PTR_W'(depth_q);
  assign can_push  = depth_q < CNT_W'(NUM_SLOTS);

  // An entry that was never pushed reads as its own position.
  assign top_slot_o = rd_written_q ? rd_mem_q : rd_addr_q;
  assign depth_o    = depth_q;

  always_comb begin
    depth_d   = depth_q;
    written_d = written_q;
    if (ctrl_i.pop) begin
      depth_d = depth_q - CNT_W'(1);
    end else if (ctrl_i.push && can_push) begin
      depth_d              = depth_q + CNT_W'(1);
      written_d[push_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && can_push) begin
      stack_mem[push_addr] <= push_slot_i;
    end
    if (ctrl_i.rd) begin
      rd_mem_q     <= stack_mem[top_addr];
      rd_written_q <= written_q[top_addr];
      rd_addr_q    <= top_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q   <= CNT_W'(NUM_SLOTS);
      written_q <= '0;
    end else begin
      depth_q   <= depth_d;
      written_q <= written_d;
    end
  end

`ifndef SYNTHESIS
  // Popping an empty stack would corrupt the depth.
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> depth_q != '0)
    else $error("free stack popped while empty");

  // Every free slot fits on the stack, so a push never finds it full.
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> can_push)
    else $error("free stack pushed while full");
`endif

endmodule

### hw/rtl/sfs_slot_table.sv
module sfs_slot_table #(
  parameter int unsigned NUM_SLOTS  = 32,
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sfs_pkg::tbl_ctrl_t           ctrl_i,
  input  logic [$clog2(NUM_SLOTS)-1:0] rd_addr_i,
  input  logic [$clog2(NUM_SLOTS)-1:0] wr_addr_i,
  input  logic [DATA_WIDTH-1:0]        wr_data_i,
  output logic [DATA_WIDTH-1:0]        rd_data_o,
  output logic                         rd_used_o
);

  logic [DATA_WIDTH-1:0] data_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  used_q, used_d;
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic                  rd_used_q;

  assign rd_data_o = rd_data_q;
  assign rd_used_o = rd_used_q;

  always_comb begin
    used_d = used_q;
    if (ctrl_i.wr) begin
      used_d[wr_addr_i] = 1'b1;
    end else if (ctrl_i.clr) begin
      used_d[wr_addr_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      data_mem[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd) begin
      rd_data_q <= data_mem[rd_addr_i];
      rd_used_q <= used_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

`ifndef SYNTHESIS
  // A slot handed out by an add must have been free.
  a_alloc_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.wr |-> !used_q[wr_addr_i])
    else $error("allocated a slot that is already in use");

  // A remove only releases a slot that is in use.
  a_release_used_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clr |-> used_q[wr_addr_i])
    else $error("released a slot that is not in use");
`endif

endmodule

### hw/rtl/slot_allocator_free_stack_core.sv
// A request is accepted in IDLE and the memories are read on acceptance; in EXEC, once the
// result register is free, the result is loaded and the memories are written back, and the
// next request is taken only after that write.
// Reset: all slot numbers are free (slot NUM_SLOTS-1 on top), no slot in use and the
// live count is zero. The data memory is not cleared; its data is used only for used slots.
module slot_allocator_free_stack_core #(
  parameter int unsigned NUM_SLOTS  = 32,
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Request channel.
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [sfs_pkg::CMD_W-1:0]          command_i,
  input  logic [sfs_pkg::SLOT_IDX_W-1:0]     slot_index_i,
  input  logic [sfs_pkg::ENTRY_W-1:0]        entry_data_i,
  // Result channel.
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               ok_o,
  output logic [sfs_pkg::OUT_SLOT_W-1:0]     given_slot_o,
  output logic [sfs_pkg::ENTRY_W-1:0]        read_data_o,
  output logic [sfs_pkg::COUNT_W-1:0]        live_count_o
);

  localparam int unsigned PTR_W = $clog2(NUM_SLOTS);
  localparam int unsigned CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int unsigned IDX_W = sfs_pkg::SLOT_IDX_W;

  // Two-state sequencer: IDLE takes a request and launches the memory reads,
  // EXEC uses the read data, writes back and loads the result register.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;

  // The request held for the EXEC cycle.
  sfs_pkg::cmd_e         cmd_q;
  logic [IDX_W-1:0]      idx_q;
  logic [DATA_WIDTH-1:0] data_q;

  logic [CNT_W-1:0] live_q, live_d;

  // Result register. It parts the two channels, so a finished result may wait
  // while the next request is already taken and read.
  logic                              out_valid_q, out_valid_d;
  logic                              ok_q, ok_d;
  logic [sfs_pkg::OUT_SLOT_W-1:0]    given_q, given_d;
  logic [sfs_pkg::ENTRY_W-1:0]       rdata_q, rdata_d;
  logic [sfs_pkg::COUNT_W-1:0]       count_q, count_d;

  logic in_accept;
  logic out_load;
  logic in_range_i, idx_ok;

  sfs_pkg::stk_ctrl_t stk_ctrl;
  sfs_pkg::tbl_ctrl_t tbl_ctrl;
  logic [PTR_W-1:0]      top_slot;
  logic [CNT_W-1:0]      depth;
  logic [PTR_W-1:0]      tbl_wr_addr;
  logic [DATA_WIDTH-1:0] tbl_rd_data;
  logic                  tbl_rd_used;

  // A new request is taken only in IDLE. Because every memory write happens at the
  // edge that ends EXEC, the reads launched on acceptance always see the updated
  // stack and table: no forwarding path is needed.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // EXEC completes once the result register is free or is being emptied.
  assign out_load = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);

  assign in_range_i = ({1'b0, slot_index_i} < (IDX_W + 1)'(NUM_SLOTS));
  assign idx_ok     = ({1'b0, idx_q} < (IDX_W + 1)'(NUM_SLOTS));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Execute the held request against the read data.
  always_comb begin
    stk_ctrl     = '0;
    tbl_ctrl     = '0;
    tbl_wr_addr  = top_slot;
    live_d       = live_q;
    ok_d         = 1'b0;
    given_d      = '0;
    rdata_d      = '0;

    // Reads go out with the request; a read index outside the pool is not issued.
    stk_ctrl.rd = in_accept;
    tbl_ctrl.rd = in_accept && in_range_i;

    if (out_load) begin
      case (cmd_q)
        sfs_pkg::CMD_ADD: begin
          // Every free slot sits on the stack (live count plus depth is always the
          // pool size), so an empty stack means the pool is full.
          if (depth != '0) begin
            stk_ctrl.pop = 1'b1;
            tbl_ctrl.wr  = 1'b1;
            tbl_wr_addr  = top_slot;
            live_d       = live_q + CNT_W'(1);
            ok_d         = 1'b1;
            given_d      = sfs_pkg::OUT_SLOT_W'(top_slot);
          end else begin
            given_d = sfs_pkg::OUT_SLOT_W'(NUM_SLOTS);
          end
        end
        sfs_pkg::CMD_REMOVE: begin
          if (idx_ok && tbl_rd_used) begin
            stk_ctrl.push = 1'b1;
            tbl_ctrl.clr  = 1'b1;
            tbl_wr_addr   = idx_q[PTR_W-1:0];
            live_d        = live_q - CNT_W'(1);
            ok_d          = 1'b1;
          end
        end
        sfs_pkg::CMD_READ: begin
          if (idx_ok && tbl_rd_used) begin
            ok_d    = 1'b1;
            rdata_d = sfs_pkg::ENTRY_W'(tbl_rd_data);
          end
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end

    count_d = sfs_pkg::COUNT_W'(live_d);

    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  sfs_free_stack #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_free_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (stk_ctrl),
    .push_slot_i (idx_q[PTR_W-1:0]),
    .top_slot_o  (top_slot),
    .depth_o     (depth)
  );

  sfs_slot_table #(
    .NUM_SLOTS  (NUM_SLOTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_slot_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (tbl_ctrl),
    .rd_addr_i (slot_index_i[PTR_W-1:0]),
    .wr_addr_i (tbl_wr_addr),
    .wr_data_i (data_q),
    .rd_data_o (tbl_rd_data),
    .rd_used_o (tbl_rd_used)
  );

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q  <= sfs_pkg::cmd_e'(command_i);
      idx_q  <= slot_index_i;
      data_q <= entry_data_i[DATA_WIDTH-1:0];
    end
    if (out_load) begin
      ok_q    <= ok_d;
      given_q <= given_d;
      rdata_q <= rdata_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = ok_q;
  assign given_slot_o = given_q;
  assign read_data_o  = rdata_q;
  assign live_count_o = count_q;

`ifndef SYNTHESIS
  // Live slots and free stack entries always account for the whole pool.
  a_pool_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, live_q} + {1'b0, depth}) == (CNT_W + 1)'(NUM_SLOTS))
    else $error("live count and stack depth do not add up to the pool size");

  // An accepted request always moves to the execute cycle.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == ST_EXEC)
    else $error("accepted request did not enter execute");
`endif

endmodule
